// ===== rtl/pwr_pkg.sv =====
// Package for the per-core work ring block: sizes, codes and shared structs.
// No dependencies; used by every module in rtl.
package pwr_pkg;

  localparam int RING_DEPTH_DEF   = 64;
  localparam int NUM_RINGS_DEF    = 8;
  localparam int PAYLOAD_BITS_DEF = 48;

  localparam int KIND_W    = 2;
  localparam int RING_W    = 3;
  localparam int MSG_W     = 3;
  localparam int PAY_W     = 48;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 6;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 4;

  localparam logic [KIND_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] REQ_OWN   = 2'd1;
  localparam logic [KIND_W-1:0] REQ_STEAL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd2;

  localparam logic [MSG_W-1:0] MSG_ADD  = 3'd1;
  localparam logic [MSG_W-1:0] MSG_STOP = 3'd3;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;      // latch request, set ring cursor to the requested ring
    logic scan;      // run one ring scan with the current cursor
    logic advance;   // move cursor to next candidate ring
    logic commit;    // apply found slot update and build result
    logic fail;      // build failure result with status
    logic [STATUS_W-1:0] fail_status;
  } pwr_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic       is_push;
    logic       is_steal;
    logic       bad_kind;
    logic       inactive;
    logic       found;     // registered result of last scan
    logic       last_ring; // no more candidate rings
  } pwr_stat_t;

endpackage

// ===== rtl/pwr_datapath.sv =====
// Datapath: slot flags, kinds, payload memory, hints, counters, scan logic.
// Depends on pwr_pkg.
module pwr_datapath #(
  parameter int RING_DEPTH   = pwr_pkg::RING_DEPTH_DEF,
  parameter int NUM_RINGS    = pwr_pkg::NUM_RINGS_DEF,
  parameter int PAYLOAD_BITS = pwr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [pwr_pkg::CFG_W-1:0] cfg_data,
  input  logic [pwr_pkg::KIND_W-1:0] kind,
  input  logic [pwr_pkg::RING_W-1:0] ring_index,
  input  logic [pwr_pkg::MSG_W-1:0] msg_kind,
  input  logic [pwr_pkg::PAY_W-1:0] payload,
  input  pwr_pkg::pwr_cmd_t cmd,
  output pwr_pkg::pwr_stat_t stat,
  output logic [pwr_pkg::STATUS_W-1:0] r_status,
  output logic [pwr_pkg::RING_W-1:0] r_source,
  output logic [pwr_pkg::SLOT_W-1:0] r_slot,
  output logic [pwr_pkg::MSG_W-1:0] r_kind,
  output logic [pwr_pkg::PAY_W-1:0] r_payload,
  output logic r_stop,
  output logic r_stolen,
  output logic [pwr_pkg::CNT_W-1:0] r_done,
  output logic [pwr_pkg::CNT_W-1:0] r_add,
  output logic [pwr_pkg::CNT_W-1:0] r_steal
);
  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RW = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int NW = $clog2(NUM_RINGS + 1);
  localparam int AW = RW + IW;
  localparam int NSLOT = NUM_RINGS * RING_DEPTH;
  localparam logic [IW-1:0] HALF = IW'(RING_DEPTH / 2);
  localparam logic [IW:0] DEPTH_W = (IW+1)'(RING_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

  logic [pwr_pkg::CFG_W-1:0] active_rings;
  logic [RING_DEPTH-1:0] ready [NUM_RINGS];
  logic [RING_DEPTH-1:0] stop_map [NUM_RINGS];
  logic [pwr_pkg::MSG_W-1:0] kind_mem [NSLOT];
  logic [PAYLOAD_BITS-1:0] pay_mem [NSLOT];
  logic [IW-1:0] hint [NUM_RINGS];
  logic [pwr_pkg::CNT_W-1:0] done_cnt [NUM_RINGS];
  logic [pwr_pkg::CNT_W-1:0] add_cnt [NUM_RINGS];
  logic [pwr_pkg::CNT_W-1:0] steal_cnt [NUM_RINGS];

  logic [pwr_pkg::KIND_W-1:0] q_kind;
  logic [pwr_pkg::MSG_W-1:0] q_msg;
  logic [PAYLOAD_BITS-1:0] q_pay;
  logic [NW-1:0] n_eff;
  logic [RW-1:0] cur;
  logic [NW-1:0] tries;
  logic own_phase;
  logic found;
  logic [IW-1:0] found_idx;
  logic [pwr_pkg::MSG_W-1:0] rd_kind;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic bad_kind;
  logic inactive;

  // effective ring count
  logic [NW-1:0] n_cfg;
  always_comb begin
    if (active_rings == '0) n_cfg = NW'(1);
    else if ({28'd0, active_rings} > NUM_RINGS) n_cfg = NW'(NUM_RINGS);
    else n_cfg = NW'(active_rings);
  end

  // rotating priority find over one ring
  logic [RING_DEPTH-1:0] cand;
  logic [IW-1:0] start;
  logic [IW:0] half_sum;
  logic [IW:0] idx_sum;
  logic [2*RING_DEPTH-1:0] rot2;
  logic [RING_DEPTH-1:0] rot;
  logic hit;
  logic [IW-1:0] off;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] scan_next;
  always_comb begin
    if (q_kind == pwr_pkg::REQ_PUSH) cand = ~ready[cur];
    else if (own_phase) cand = ready[cur];
    else cand = ready[cur] & ~stop_map[cur];
    half_sum = {1'b0, hint[cur]} + {1'b0, HALF};
    if (own_phase) start = hint[cur];
    else if (half_sum >= DEPTH_W) start = IW'(half_sum - DEPTH_W);
    else start = IW'(half_sum);
    rot2 = {cand, cand} >> start;
    rot = rot2[RING_DEPTH-1:0];
    hit = |rot;
    off = '0;
    for (int i = RING_DEPTH - 1; i >= 0; i--) begin
      if (rot[i]) off = IW'(i);
    end
    idx_sum = {1'b0, start} + {1'b0, off};
    if (idx_sum >= DEPTH_W) scan_idx = IW'(idx_sum - DEPTH_W);
    else scan_idx = IW'(idx_sum);
    scan_next = (scan_idx == LAST_IDX) ? '0 : scan_idx + IW'(1);
  end

  logic [IW-1:0] found_next;
  assign found_next = (found_idx == LAST_IDX) ? '0 : found_idx + IW'(1);

  logic [RW-1:0] nxt_ring;
  always_comb begin
    if (NW'(cur) + NW'(1) >= n_eff) nxt_ring = '0;
    else nxt_ring = cur + RW'(1);
  end

  wire [AW-1:0] addr = {cur, found_idx};
  wire [AW-1:0] waddr = {cur, scan_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rings <= pwr_pkg::CFG_W'(1);
      for (int r = 0; r < NUM_RINGS; r++) begin
        ready[r] <= '0;
        stop_map[r] <= '0;
        hint[r] <= '0;
        done_cnt[r] <= '0;
        add_cnt[r] <= '0;
        steal_cnt[r] <= '0;
      end
      found <= 1'b0;
    end else begin
      if (cfg_we) active_rings <= cfg_data;
      if (cmd.load) begin
        q_kind <= kind;
        q_msg <= msg_kind;
        q_pay <= PAYLOAD_BITS'(payload);
        n_eff <= n_cfg;
        cur <= RW'(ring_index);
        tries <= NW'(1);
        own_phase <= 1'b1;
        bad_kind <= (kind != pwr_pkg::REQ_PUSH) && (kind != pwr_pkg::REQ_OWN)
                    && (kind != pwr_pkg::REQ_STEAL);
        inactive <= (pwr_pkg::RING_W+NW)'(ring_index) >= (pwr_pkg::RING_W+NW)'(n_cfg);
        found <= 1'b0;
      end
      if (cmd.scan) begin
        found <= hit;
        found_idx <= scan_idx;
        if (hit && q_kind == pwr_pkg::REQ_PUSH) begin
          // claim the free slot now; the slot memories are written by the same scan
          ready[cur][scan_idx] <= 1'b1;
          stop_map[cur][scan_idx] <= (q_msg == pwr_pkg::MSG_STOP);
          hint[cur] <= scan_next;
        end
      end
      if (cmd.advance) begin
        cur <= nxt_ring;
        tries <= tries + NW'(1);
        if (q_kind != pwr_pkg::REQ_PUSH) own_phase <= 1'b0;
        found <= 1'b0;
      end
      if (cmd.commit) begin
        if (q_kind == pwr_pkg::REQ_PUSH) begin
          r_done <= done_cnt[cur];
          r_add <= add_cnt[cur];
          r_steal <= steal_cnt[cur];
        end else begin
          ready[cur][found_idx] <= 1'b0;
          hint[cur] <= found_next;
          done_cnt[cur] <= done_cnt[cur] + 32'd1;
          r_done <= done_cnt[cur] + 32'd1;
          if (rd_kind == pwr_pkg::MSG_ADD) begin
            add_cnt[cur] <= add_cnt[cur] + 32'(rd_pay);
            r_add <= add_cnt[cur] + 32'(rd_pay);
          end else r_add <= add_cnt[cur];
          if (!own_phase) begin
            steal_cnt[cur] <= steal_cnt[cur] + 32'd1;
            r_steal <= steal_cnt[cur] + 32'd1;
          end else r_steal <= steal_cnt[cur];
        end
        r_status <= pwr_pkg::ST_DONE;
        r_source <= pwr_pkg::RING_W'(cur);
        r_slot <= pwr_pkg::SLOT_W'(found_idx);
        r_kind <= (q_kind == pwr_pkg::REQ_PUSH) ? '0 : rd_kind;
        r_payload <= (q_kind == pwr_pkg::REQ_PUSH) ? '0 : pwr_pkg::PAY_W'(rd_pay);
        r_stop <= (q_kind != pwr_pkg::REQ_PUSH) && own_phase
                  && (rd_kind == pwr_pkg::MSG_STOP);
        r_stolen <= (q_kind != pwr_pkg::REQ_PUSH) && !own_phase;
      end
      if (cmd.fail) begin
        r_status <= cmd.fail_status;
        r_source <= '0;
        r_slot <= '0;
        r_kind <= '0;
        r_payload <= '0;
        r_stop <= 1'b0;
        r_stolen <= 1'b0;
        r_done <= '0;
        r_add <= '0;
        r_steal <= '0;
      end
    end
  end

  // slot memories: write on push scan hit, registered read of found slot
  always_ff @(posedge clk) begin
    if (cmd.scan && hit && q_kind == pwr_pkg::REQ_PUSH) begin
      kind_mem[waddr] <= q_msg;
      pay_mem[waddr] <= q_pay;
    end
    rd_kind <= kind_mem[addr];
    rd_pay <= pay_mem[addr];
  end

  always_comb begin
    stat.is_push = (q_kind == pwr_pkg::REQ_PUSH);
    stat.is_steal = (q_kind == pwr_pkg::REQ_STEAL);
    stat.bad_kind = bad_kind;
    stat.inactive = inactive;
    stat.found = found;
    stat.last_ring = (tries >= n_eff);
  end

endmodule

// ===== rtl/pwr_ctrl.sv =====
// Controller state machine: sequences ring scans for one request at a time.
// Depends on pwr_pkg.
module pwr_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  pwr_pkg::pwr_stat_t stat,
  output pwr_pkg::pwr_cmd_t cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_EVAL  = 6'b001000,
    S_READ  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad_kind) begin
          cmd.fail = 1'b1;
          cmd.fail_status = pwr_pkg::ST_NONE;
          state_next = S_OUT;
        end else if (stat.inactive) begin
          cmd.fail = 1'b1;
          cmd.fail_status = pwr_pkg::ST_INACTIVE;
          state_next = S_OUT;
        end else state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.found) state_next = S_READ;
        else if (!stat.last_ring && (stat.is_push || stat.is_steal)) begin
          cmd.advance = 1'b1;
          state_next = S_SCAN;
        end else begin
          cmd.fail = 1'b1;
          cmd.fail_status = pwr_pkg::ST_NONE;
          state_next = S_OUT;
        end
      end
      S_READ: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit && cmd.fail)) else $error("commit and fail together");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_scan_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |=> (state == S_EVAL)) else $error("scan not evaluated");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> $past(state == S_IDLE) || state == S_IDLE)
    else $error("load while busy");

endmodule

// ===== rtl/per_core_work_ring_with_steal_top.sv =====
// Top level: per-core work rings with spill-on-push and work stealing.
// Flow: one item in flight; a new input is taken only back in idle, after the result
// transfer. Each ring visited (own, spill or steal) is scanned, then evaluated.
// Failures: bad kind or inactive ring are reported from the check state; nothing found after the last ring.
// Reset (rst, synchronous): all slots empty, hints and counters zero, active_rings 1.
module per_core_work_ring_with_steal_top #(
  parameter int RING_DEPTH   = pwr_pkg::RING_DEPTH_DEF,
  parameter int NUM_RINGS    = pwr_pkg::NUM_RINGS_DEF,
  parameter int PAYLOAD_BITS = pwr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [pwr_pkg::CFG_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [pwr_pkg::KIND_W-1:0] kind,
  input  logic [pwr_pkg::RING_W-1:0] ring_index,
  input  logic [pwr_pkg::MSG_W-1:0] msg_kind,
  input  logic [pwr_pkg::PAY_W-1:0] payload,
  output logic out_valid,
  input  logic out_stall,
  output logic [pwr_pkg::STATUS_W-1:0] status,
  output logic [pwr_pkg::RING_W-1:0] source_ring,
  output logic [pwr_pkg::SLOT_W-1:0] slot_index,
  output logic [pwr_pkg::MSG_W-1:0] item_kind,
  output logic [pwr_pkg::PAY_W-1:0] item_payload,
  output logic got_stop,
  output logic was_stolen,
  output logic [pwr_pkg::CNT_W-1:0] done_total,
  output logic [pwr_pkg::CNT_W-1:0] add_total,
  output logic [pwr_pkg::CNT_W-1:0] steal_total
);
  pwr_pkg::pwr_cmd_t cmd;
  pwr_pkg::pwr_stat_t stat;

  // Sequencer: accept, check, scan ring by ring, commit, hold the result.
  pwr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  // Storage and the one-ring rotating find.
  pwr_datapath #(
    .RING_DEPTH(RING_DEPTH), .NUM_RINGS(NUM_RINGS), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .kind, .ring_index, .msg_kind, .payload,
    .cmd, .stat,
    .r_status(status), .r_source(source_ring), .r_slot(slot_index),
    .r_kind(item_kind), .r_payload(item_payload), .r_stop(got_stop),
    .r_stolen(was_stolen), .r_done(done_total), .r_add(add_total),
    .r_steal(steal_total)
  );

endmodule
